/* hw/rtl/bir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bir_pkg;

    // default geometry and precision
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 16;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int LOAD_W     = 8;
    localparam int QUERY_W    = 12;
    localparam int SCALE_W    = 24;
    localparam int SIZE_W     = 9;
    localparam int SCALE_FRAC = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd2;

    localparam logic [SCALE_W-1:0] RST_INV_SCALE  = 24'd65536;
    localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = 9'd256;

    // neighbour being fetched from the frame store
    typedef enum logic [1:0] {
        RD_00 = 2'd0,
        RD_10 = 2'd1,
        RD_01 = 2'd2,
        RD_11 = 2'd3
    } t_rd_sel;

    typedef struct packed {
        logic    load_wr;
        logic    capture;
        logic    map;
        logic    clamp;
        t_rd_sel rd_sel;
        logic    row_first;
        logic    row_second;
        logic    sum_first;
        logic    sum_second;
        logic    out_load;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hw/rtl/bir_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/bir_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bir_ctrl
    import bir_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_query,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MAP   = 10'b00_0000_0010,
        S_CLAMP = 10'b00_0000_0100,
        S_RD0   = 10'b00_0000_1000,
        S_RD1   = 10'b00_0001_0000,
        S_RD2   = 10'b00_0010_0000,
        S_RD3   = 10'b00_0100_0000,
        S_D3    = 10'b00_1000_0000,
        S_SUM   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_query) begin
                        cmd.capture = 1'b1;
                        n_state     = S_MAP;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_MAP: begin
                cmd.map = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                n_state   = S_RD0;
            end
            S_RD0: begin
                cmd.rd_sel = RD_00;
                n_state    = S_RD1;
            end
            S_RD1: begin
                cmd.rd_sel    = RD_10;
                cmd.row_first = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                cmd.rd_sel     = RD_01;
                cmd.row_second = 1'b1;
                n_state        = S_RD3;
            end
            S_RD3: begin
                // upper row is complete: fold it in while the lower row starts
                cmd.rd_sel    = RD_11;
                cmd.row_first = 1'b1;
                cmd.sum_first = 1'b1;
                n_state       = S_D3;
            end
            S_D3: begin
                cmd.row_second = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                cmd.sum_second = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

/* hw/rtl/bir_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bir_dpath
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [LOAD_W-1:0]     i_load_x,
    input  wire logic [LOAD_W-1:0]     i_load_y,
    input  wire logic [PIX_W-1:0]      i_load_value,
    input  wire logic [QUERY_W-1:0]    i_query_x,
    input  wire logic [QUERY_W-1:0]    i_query_y,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [PIX_W-1:0]      o_resized_value,
    output logic                       o_edge_clamped
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WSW   = $clog2(MAX_WIDTH + 1);
    localparam int HSW   = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = QUERY_W + SCALE_W;
    localparam int IPW   = PW - SCALE_FRAC;
    localparam int FXW   = FRAC_BITS + SCALE_FRAC;
    localparam int WTW   = FRAC_BITS + 1;
    localparam int MXW   = WTW + PIX_W;
    localparam int SMW   = WTW + MXW;
    localparam int TOPW  = SMW - 2 * FRAC_BITS;

    localparam logic [WTW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [AW-1:0] pix_addr(input logic [AW-1:0] x, input logic [AW-1:0] y);
        return y * AW'(MAX_WIDTH) + x;
    endfunction

    // configuration registers
    logic [SCALE_W-1:0] r_inv_scale;
    logic [SIZE_W-1:0]  r_src_w;
    logic [SIZE_W-1:0]  r_src_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= RST_INV_SCALE;
            r_src_w     <= RST_SRC_WIDTH;
            r_src_h     <= RST_SRC_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INV_SCALE:  r_inv_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_SRC_WIDTH:  r_src_w     <= i_cfg_data[SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_src_h     <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // query capture and coordinate mapping
    logic [QUERY_W-1:0] r_qx, r_qy;
    logic [PW-1:0]      r_px, r_py;
    logic [PW-1:0]      m_px, m_py;

    assign m_px = r_qx * r_inv_scale;
    assign m_py = r_qy * r_inv_scale;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
        if (i_cmd.map) begin
            r_px <= m_px;
            r_py <= m_py;
        end
    end

    // effective image size, clamped indices and fractions
    logic [WSW-1:0]       eff_w, last_w, xb1;
    logic [HSW-1:0]       eff_h, last_h, yb1;
    logic [IPW-1:0]       ipx, ipy;
    logic [FXW-1:0]       fxe, fye;
    logic                 cx, cy;
    logic [XW-1:0]        xb, xn;
    logic [YW-1:0]        yb, yn;
    logic [FRAC_BITS-1:0] fx, fy;

    always_comb begin
        if (r_src_w == '0) begin
            eff_w = WSW'(1);
        end else if (32'(r_src_w) > 32'(MAX_WIDTH)) begin
            eff_w = WSW'(MAX_WIDTH);
        end else begin
            eff_w = WSW'(r_src_w);
        end
        if (r_src_h == '0) begin
            eff_h = HSW'(1);
        end else if (32'(r_src_h) > 32'(MAX_HEIGHT)) begin
            eff_h = HSW'(MAX_HEIGHT);
        end else begin
            eff_h = HSW'(r_src_h);
        end
        last_w = eff_w - WSW'(1);
        last_h = eff_h - HSW'(1);

        ipx = r_px[PW-1:SCALE_FRAC];
        ipy = r_py[PW-1:SCALE_FRAC];
        // fraction rescaled to FRAC_BITS: top bits of the 16-bit fraction padded with zeros
        fxe = {r_px[SCALE_FRAC-1:0], FRAC_BITS'(0)};
        fye = {r_py[SCALE_FRAC-1:0], FRAC_BITS'(0)};

        cx = (ipx > IPW'(last_w));
        cy = (ipy > IPW'(last_h));
        xb = cx ? last_w[XW-1:0] : ipx[XW-1:0];
        yb = cy ? last_h[YW-1:0] : ipy[YW-1:0];
        fx = cx ? '0 : fxe[FXW-1:SCALE_FRAC];
        fy = cy ? '0 : fye[FXW-1:SCALE_FRAC];

        xb1 = WSW'(xb) + WSW'(1);
        yb1 = HSW'(yb) + HSW'(1);
        xn  = (xb1 < eff_w) ? xb1[XW-1:0] : last_w[XW-1:0];
        yn  = (yb1 < eff_h) ? yb1[YW-1:0] : last_h[YW-1:0];
    end

    logic [XW-1:0]        r_xb, r_xn;
    logic [YW-1:0]        r_yb, r_yn;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic                 r_clamped;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_xb      <= xb;
            r_xn      <= xn;
            r_yb      <= yb;
            r_yn      <= yn;
            r_fx      <= fx;
            r_fy      <= fy;
            r_clamped <= cx | cy;
        end
    end

    // frame store access: loads write, queries read four neighbours
    logic [AW-1:0]    rd_addr, wr_addr, ram_addr;
    logic             load_ok, ram_we;
    logic [PIX_W-1:0] ram_rdata;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_00:   rd_addr = pix_addr(AW'(r_xb), AW'(r_yb));
            RD_10:   rd_addr = pix_addr(AW'(r_xn), AW'(r_yb));
            RD_01:   rd_addr = pix_addr(AW'(r_xb), AW'(r_yn));
            RD_11:   rd_addr = pix_addr(AW'(r_xn), AW'(r_yn));
            default: rd_addr = pix_addr(AW'(r_xb), AW'(r_yb));
        endcase
    end

    assign load_ok  = (32'(i_load_x) < 32'(MAX_WIDTH)) && (32'(i_load_y) < 32'(MAX_HEIGHT));
    assign wr_addr  = pix_addr(AW'(i_load_x), AW'(i_load_y));
    assign ram_we   = i_cmd.load_wr & load_ok;
    assign ram_addr = i_cmd.load_wr ? wr_addr : rd_addr;

    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_load_value),
        .o_rdata (ram_rdata)
    );

    // blend: each row along x, then the two rows along y
    logic [WTW-1:0] wx0, wx1, wy0, wy1, wy_sel;
    logic [MXW-1:0] m_x0, m_x1, r_row;
    logic [SMW-1:0] m_y, r_sum;

    assign wx0    = ONE - WTW'(r_fx);
    assign wx1    = WTW'(r_fx);
    assign wy0    = ONE - WTW'(r_fy);
    assign wy1    = WTW'(r_fy);
    assign wy_sel = i_cmd.sum_second ? wy1 : wy0;
    assign m_x0   = wx0 * ram_rdata;
    assign m_x1   = wx1 * ram_rdata;
    assign m_y    = wy_sel * r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_first) begin
            r_row <= m_x0;
        end else if (i_cmd.row_second) begin
            r_row <= r_row + m_x1;
        end
        if (i_cmd.sum_first) begin
            r_sum <= m_y;
        end else if (i_cmd.sum_second) begin
            r_sum <= r_sum + m_y;
        end
    end

    // truncate and saturate into the output register
    logic [TOPW-1:0]  sum_top;
    logic [PIX_W-1:0] value;
    logic [PIX_W-1:0] r_o_value;
    logic             r_o_clamped;

    assign sum_top = r_sum[SMW-1:2*FRAC_BITS];
    assign value   = (sum_top > TOPW'(255)) ? 8'hff : sum_top[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_value   <= value;
            r_o_clamped <= r_clamped;
        end
    end

    assign o_resized_value = r_o_value;
    assign o_edge_clamped  = r_o_clamped;

endmodule

`default_nettype wire

/* hw/rtl/bilinear_image_resize.sv */
// a load transfer writes the frame store; loads are taken back to back while no query is in flight
// a query transfer steps through map, clamp, four neighbour reads from the
// single-port frame store, a drain, sum and out states, where it waits while an
// earlier result is unaccepted; input is ready again once the result turns valid
// reset: synchronous active low, restores scale 1.0 and 256x256 size, drops any
// pending result; frame store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module bilinear_image_resize
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // load_x, load_y, load_value, query_x, query_y
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // resized_value
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // edge_clamped
    output logic                       m_axis_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;

    bir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_query  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    bir_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_load_x        (s_axis_tdata[7:0]),
        .i_load_y        (s_axis_tdata[15:8]),
        .i_load_value    (s_axis_tdata[23:16]),
        .i_query_x       (s_axis_tdata[35:24]),
        .i_query_y       (s_axis_tdata[47:36]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_resized_value (m_axis_tdata),
        .o_edge_clamped  (m_axis_tuser)
    );

endmodule

`default_nettype wire
